@@ rtl/rbc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the cartridge boot checksum block.
// Holds the variant codes, register indexes, transaction and accumulator types, rotate helper.
package rbc_pkg;

    typedef enum logic [1:0] {
        MODE_STANDARD = 2'd0,
        MODE_6103     = 2'd1,
        MODE_6105     = 2'd2,
        MODE_6106     = 2'd3
    } rbc_mode_t;

    localparam logic REG_VARIANT_MODE = 1'b0;
    localparam logic REG_SEED_VALUE   = 1'b1;

    localparam logic [31:0] SEED_AT_RESET = 32'hF8CA_4DDC;

    typedef struct packed {
        logic [31:0] data;
        logic [31:0] aux;
        logic        last;
        logic [31:0] rot;
    } rbc_item_t;

    typedef struct packed {
        logic [31:0] mix;
        logic [31:0] swap;
        logic [31:0] xr;
        logic [31:0] carry;
        logic [31:0] rot;
        logic [31:0] sum;
    } rbc_acc_t;

    function automatic logic [31:0] rbc_rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

endpackage

@@ rtl/rom_boot_checksum.sv @@
`timescale 1ns / 1ps
// Top level of the cartridge boot checksum block: configuration registers and the three stages.
// Depends on rbc_pkg, rbc_front, rbc_engine and rbc_final.
//
// One cartridge word is taken per clock cycle, sustained, as long as the result side does not
// stall. The rate is set by the accumulator engine, which folds one word into all six
// accumulators in a single cycle. A transaction with last_word set yields one result
// transaction: it waits at the head of the input queue, where the engine folds the word and
// loads the snapshot stage, then passes through the product stage (the 6106 multiplies) and
// the output register. The input queue holds QUEUE_DEPTH words, so input keeps flowing while
// a finished result waits on out_stall, until the queue fills behind a held last word.
// Write variant_mode and seed_value only while the block is idle; the seed is loaded into the
// accumulators at the first word of each run.
module rom_boot_checksum #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [31:0] aux_word,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] checksum_one,
    output logic [31:0] checksum_two
);

    rbc_pkg::rbc_mode_t mode_reg;
    logic [31:0]        seed_reg;
    logic               q_valid;
    rbc_pkg::rbc_item_t q_item;
    logic               q_pop;
    logic               fin_ready;
    logic               fin_take;
    rbc_pkg::rbc_acc_t  fin_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rbc_pkg::MODE_STANDARD;
            seed_reg <= rbc_pkg::SEED_AT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rbc_pkg::REG_VARIANT_MODE: mode_reg <= rbc_pkg::rbc_mode_t'(cfg_data[1:0]);
                rbc_pkg::REG_SEED_VALUE:   seed_reg <= cfg_data;
                default:                   seed_reg <= seed_reg;
            endcase
        end
    end

    rbc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_word (data_word),
        .aux_word  (aux_word),
        .last_word (last_word),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    rbc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .seed      (seed_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .fin_ready (fin_ready),
        .fin_take  (fin_take),
        .fin_acc   (fin_acc)
    );

    rbc_final u_final (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .take         (fin_take),
        .acc_in       (fin_acc),
        .ready        (fin_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .checksum_one (checksum_one),
        .checksum_two (checksum_two)
    );

endmodule

@@ rtl/rbc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input transactions, precomputes the word rotate, queues them.
// Depends on rbc_pkg.
module rbc_front #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         data_word,
    input  logic [31:0]         aux_word,
    input  logic                last_word,
    output logic                q_valid,
    output rbc_pkg::rbc_item_t  q_item,
    input  logic                q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rbc_pkg::rbc_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;
    rbc_pkg::rbc_item_t item_in;

    assign in_stall = (count_reg == CNT_FULL);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.data = data_word;
        item_in.aux  = aux_word;
        item_in.last = last_word;
        item_in.rot  = rbc_pkg::rbc_rotl(data_word, data_word[4:0]);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

@@ rtl/rbc_engine.sv @@
`timescale 1ns / 1ps
// Back end accumulator engine: applies one queued word per cycle to the six accumulators.
// Depends on rbc_pkg. A last word waits at the queue head until fin_ready is high.
module rbc_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  rbc_pkg::rbc_mode_t  mode,
    input  logic [31:0]         seed,
    input  logic                q_valid,
    input  rbc_pkg::rbc_item_t  q_item,
    output logic                q_pop,
    input  logic                fin_ready,
    output logic                fin_take,
    output rbc_pkg::rbc_acc_t   fin_acc
);

    rbc_pkg::rbc_acc_t acc_reg, acc_next;
    rbc_pkg::rbc_acc_t base;
    logic              fresh_reg;
    logic [32:0]       sum_wide;
    logic [31:0]       mix_term;

    assign q_pop    = q_valid && (!q_item.last || fin_ready);
    assign fin_take = q_pop && q_item.last;
    assign fin_acc  = acc_next;

    always_comb
    begin
        if (fresh_reg)
        begin
            base = '{mix: seed, swap: seed, xr: seed, carry: seed, rot: seed, sum: seed};
        end
        else
        begin
            base = acc_reg;
        end
        sum_wide       = {1'b0, base.sum} + {1'b0, q_item.data};
        acc_next.sum   = sum_wide[31:0];
        acc_next.carry = base.carry + {31'd0, sum_wide[32]};
        acc_next.xr    = base.xr ^ q_item.data;
        acc_next.rot   = base.rot + q_item.rot;
        if (base.swap > q_item.data)
        begin
            acc_next.swap = base.swap ^ q_item.rot;
        end
        else
        begin
            acc_next.swap = base.swap ^ acc_next.sum ^ q_item.data;
        end
        if (mode == rbc_pkg::MODE_6105)
        begin
            mix_term = q_item.aux ^ q_item.data;
        end
        else
        begin
            mix_term = acc_next.rot ^ q_item.data;
        end
        acc_next.mix = base.mix + mix_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
            acc_reg   <= '0;
        end
        else if (q_pop)
        begin
            fresh_reg <= q_item.last;
            acc_reg   <= acc_next;
        end
    end

endmodule

@@ rtl/rbc_final.sv @@
`timescale 1ns / 1ps
// Back end combiner: snapshot, product and output stages that form the two checksum words.
// Depends on rbc_pkg.
module rbc_final (
    input  logic                clk,
    input  logic                rst_n,
    input  rbc_pkg::rbc_mode_t  mode,
    input  logic                take,
    input  rbc_pkg::rbc_acc_t   acc_in,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         checksum_one,
    output logic [31:0]         checksum_two
);

    logic               s_valid_reg;
    rbc_pkg::rbc_acc_t  s_acc_reg;
    rbc_pkg::rbc_mode_t s_mode_reg;

    logic               p_valid_reg;
    logic [31:0]        p_one_reg, p_one_next;
    logic [31:0]        p_two_reg, p_two_next;
    logic [31:0]        p_xor_reg;
    logic [31:0]        p_mix_reg;
    rbc_pkg::rbc_mode_t p_mode_reg;

    logic               o_valid_reg;
    logic [31:0]        o_one_reg, o_one_next;
    logic [31:0]        o_two_reg, o_two_next;

    logic               o_adv;
    logic               p_adv;
    logic               s_adv;

    assign o_adv = p_valid_reg && (!o_valid_reg || !out_stall);
    assign p_adv = s_valid_reg && (!p_valid_reg || o_adv);
    assign s_adv = take;
    assign ready = !s_valid_reg || p_adv;

    assign out_valid    = o_valid_reg;
    assign checksum_one = o_one_reg;
    assign checksum_two = o_two_reg;

    always_comb
    begin
        if (s_mode_reg == rbc_pkg::MODE_6106)
        begin
            p_one_next = s_acc_reg.sum * s_acc_reg.carry;
            p_two_next = s_acc_reg.rot * s_acc_reg.swap;
        end
        else
        begin
            p_one_next = s_acc_reg.sum ^ s_acc_reg.carry;
            p_two_next = s_acc_reg.rot ^ s_acc_reg.swap;
        end
    end

    always_comb
    begin
        case (p_mode_reg)
            rbc_pkg::MODE_6103,
            rbc_pkg::MODE_6106:
            begin
                o_one_next = p_one_reg + p_xor_reg;
                o_two_next = p_two_reg + p_mix_reg;
            end
            default:
            begin
                o_one_next = p_one_reg ^ p_xor_reg;
                o_two_next = p_two_reg ^ p_mix_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_adv)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (p_adv)
            begin
                s_valid_reg <= 1'b0;
            end
            if (p_adv)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (o_adv)
            begin
                p_valid_reg <= 1'b0;
            end
            if (o_adv)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_adv)
        begin
            s_acc_reg  <= acc_in;
            s_mode_reg <= mode;
        end
        if (p_adv)
        begin
            p_one_reg  <= p_one_next;
            p_two_reg  <= p_two_next;
            p_xor_reg  <= s_acc_reg.xr;
            p_mix_reg  <= s_acc_reg.mix;
            p_mode_reg <= s_mode_reg;
        end
        if (o_adv)
        begin
            o_one_reg <= o_one_next;
            o_two_reg <= o_two_next;
        end
    end

endmodule

@@ rtl/rbc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the cartridge boot checksum block, bound to the top level.
// Depends on the rom_boot_checksum port list only.
module rbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_word,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] checksum_one,
    input logic [31:0] checksum_two
);

    logic [3:0] pending_reg, pending_next;
    logic       last_in;
    logic       res_out;

    assign last_in = in_valid && !in_stall && last_word;
    assign res_out = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (last_in && !res_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (res_out && !last_in)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result shown with no outstanding last word");

    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> pending_reg != 4'd0)
        else $error("input stalled with no result backlog");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(checksum_one) && $stable(checksum_two))
        else $error("result changed while stalled");

endmodule

bind rom_boot_checksum rbc_checker u_rbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .last_word    (last_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .checksum_one (checksum_one),
    .checksum_two (checksum_two)
);

@@ tb/sv/rom_boot_checksum_tb.sv @@
`timescale 1ns / 1ps
// Testbench for rom_boot_checksum: random and directed cartridge word runs with idling on both
// sides, checked against an in-bench checksum tracker. Depends on rbc_pkg and the RTL only.

class boot_sum_tracker;
    typedef struct packed {
        logic [31:0] one;
        logic [31:0] two;
    } sum_pair_t;

    rbc_pkg::rbc_mode_t mode;
    logic [31:0]        seed;
    rbc_pkg::rbc_acc_t  acc;
    bit                 fresh;
    sum_pair_t          sums_due[$];
    int                 errors;

    function new();
        mode   = rbc_pkg::MODE_STANDARD;
        seed   = rbc_pkg::SEED_AT_RESET;
        acc    = '0;
        fresh  = 1'b1;
        errors = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
        if (idx == rbc_pkg::REG_VARIANT_MODE)
            mode = rbc_pkg::rbc_mode_t'(val[1:0]);
        else
            seed = val;
    endfunction

    function int due();
        return sums_due.size();
    endfunction

    function void take_word(logic [31:0] d, logic [31:0] a, logic l);
        logic [32:0] wide;
        logic [31:0] r;
        logic [4:0]  n;
        sum_pair_t   p;
        if (fresh)
        begin
            acc.mix   = seed;
            acc.swap  = seed;
            acc.xr    = seed;
            acc.carry = seed;
            acc.rot   = seed;
            acc.sum   = seed;
        end
        wide = {1'b0, acc.sum} + {1'b0, d};
        if (wide[32])
            acc.carry = acc.carry + 32'd1;
        acc.sum = wide[31:0];
        acc.xr  = acc.xr ^ d;
        n = d[4:0];
        if (n == 5'd0)
            r = d;
        else
            r = (d << n) | (d >> (6'd32 - {1'b0, n}));
        acc.rot = acc.rot + r;
        if (acc.swap > d)
            acc.swap = acc.swap ^ r;
        else
            acc.swap = acc.swap ^ acc.sum ^ d;
        if (mode == rbc_pkg::MODE_6105)
            acc.mix = acc.mix + (a ^ d);
        else
            acc.mix = acc.mix + (acc.rot ^ d);
        if (!l)
        begin
            fresh = 1'b0;
            return;
        end
        case (mode)
            rbc_pkg::MODE_6103:
            begin
                p.one = (acc.sum ^ acc.carry) + acc.xr;
                p.two = (acc.rot ^ acc.swap) + acc.mix;
            end
            rbc_pkg::MODE_6106:
            begin
                p.one = acc.sum * acc.carry + acc.xr;
                p.two = acc.rot * acc.swap + acc.mix;
            end
            default:
            begin
                p.one = acc.sum ^ acc.carry ^ acc.xr;
                p.two = acc.rot ^ acc.swap ^ acc.mix;
            end
        endcase
        sums_due.push_back(p);
        fresh = 1'b1;
    endfunction

    function void match_result(logic [31:0] one, logic [31:0] two);
        sum_pair_t p;
        if (sums_due.size() == 0)
        begin
            $display("%0t: unexpected result one=%h two=%h", $time, one, two);
            errors++;
            return;
        end
        p = sums_due.pop_front();
        if (one !== p.one)
        begin
            $display("%0t: checksum_one expected %h actual %h", $time, p.one, one);
            errors++;
        end
        if (two !== p.two)
        begin
            $display("%0t: checksum_two expected %h actual %h", $time, p.two, two);
            errors++;
        end
    endfunction
endclass

module rom_boot_checksum_tb;

    localparam int WORD_TARGET = 1250;
    localparam int CALM_AFTER  = 1100;
    localparam int LIMIT       = 300000;
    localparam int FLUSH       = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] data_word = '0;
    logic [31:0] aux_word = '0;
    logic        last_word = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] checksum_one;
    logic [31:0] checksum_two;

    boot_sum_tracker board = new();
    int  words_sent = 0;
    int  cycle_count = 0;
    int  hold = 0;
    bit  calm = 1'b0;

    rom_boot_checksum dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_word(data_word),
        .aux_word(aux_word),
        .last_word(last_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .checksum_one(checksum_one),
        .checksum_two(checksum_two)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.match_result(checksum_one, checksum_two);
        if (hold > 0)
        begin
            hold = hold - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            hold = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic push_word(logic [31:0] d, logic [31:0] a, logic l);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_word <= d;
        aux_word  <= a;
        last_word <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_word(d, a, l);
        words_sent++;
        calm = (words_sent >= CALM_AFTER);
    endtask

    // drop valid, wait out pending results and the pipeline tail
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.due() != 0)
            @(posedge clk);
        repeat (FLUSH) @(posedge clk);
    endtask

    task automatic configure(rbc_pkg::rbc_mode_t mode, logic [31:0] seed);
        cfg_write <= 1'b1;
        cfg_index <= rbc_pkg::REG_VARIANT_MODE;
        cfg_data  <= {30'($urandom_range(0, 32'h3FFF_FFFF)), mode};
        @(posedge clk);
        board.set_reg(rbc_pkg::REG_VARIANT_MODE, {30'd0, mode});
        cfg_index <= rbc_pkg::REG_SEED_VALUE;
        cfg_data  <= seed;
        @(posedge clk);
        board.set_reg(rbc_pkg::REG_SEED_VALUE, seed);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 63);
            3: return 32'd1 << $urandom_range(0, 31);
            4: return {27'($urandom_range(0, 32'h07FF_FFFF)), 5'd0};
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int          len;
        int          runs;
        bit          open_run;
        logic [31:0] seed;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration, single-word runs, a three-word run and zero rotate
        push_word(32'h0000_0000, 32'h0000_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_word(32'h8000_0000, 32'h0000_0000, 1'b0);
        push_word(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_001F, 32'h5A5A_5A5A, 1'b1);
        settle();

        configure(rbc_pkg::MODE_6103, 32'h0000_0000);
        push_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        settle();

        configure(rbc_pkg::MODE_6105, 32'hFFFF_FFFF);
        push_word(32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 32'h0000_0000, 1'b1);
        settle();

        configure(rbc_pkg::MODE_6106, 32'h8000_0000);
        push_word(32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0);
        push_word(32'hFFFF_FFFE, 32'h0000_0001, 1'b1);
        settle();

        // hold a run open across a configuration change
        configure(rbc_pkg::MODE_STANDARD, 32'h0F0F_0F0F);
        push_word(32'hDEAD_BEEF, 32'h0000_0000, 1'b0);
        push_word(32'h0000_0020, 32'hFFFF_FFFF, 1'b0);
        settle();
        configure(rbc_pkg::MODE_6106, 32'h0000_0000);
        push_word(32'hCAFE_F00D, 32'h1111_1111, 1'b1);
        settle();

        while (words_sent < WORD_TARGET)
        begin
            case ($urandom_range(0, 3))
                0: seed = 32'h0000_0000;
                1: seed = 32'hFFFF_FFFF;
                2: seed = rbc_pkg::SEED_AT_RESET;
                default: seed = $urandom;
            endcase
            configure(rbc_pkg::rbc_mode_t'($urandom_range(0, 3)), seed);
            open_run = ($urandom_range(0, 5) == 0);
            runs = $urandom_range(1, 4);
            for (int r = 0; r < runs; r++)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(25, 60);
                else
                    len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    push_word(pick_word(), $urandom,
                              (i == len - 1) && !(open_run && r == runs - 1));
            end
            settle();
        end

        // close any run left open
        push_word(pick_word(), $urandom, 1'b1);
        settle();

        if (board.errors == 0 && board.due() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
